// ----- sv/hknn_pkg.sv -----
// Shared constants and types for the histogram top-K nearest search block.
// Holds parameter defaults, command codes and the command control struct.
// No dependencies.
package hknn_pkg;

  localparam int TOP_K_DEF      = 10;
  localparam int NUM_BINS_DEF   = 48;
  localparam int COUNT_BITS_DEF = 24;
  localparam int ID_BITS_DEF    = 16;

  localparam int DIST_W = 54;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              last;
  } hknn_ctl_t;

endpackage

// ----- sv/hknn_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hknn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/hknn_fifo.sv -----
// Small register-based first-in first-out queue with full and empty flags.
// Used between the front and back parts and in front of the result ports.
// No dependencies.
module hknn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/hknn_front.sv -----
// Front part: accepts input transfers, stores query bins and squares bin differences.
// Depends on hknn_pkg and hknn_ram; feeds the command queue read by hknn_back.
module hknn_front #(
  parameter int NUM_BINS   = hknn_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hknn_pkg::COUNT_BITS_DEF,
  parameter int ID_BITS    = hknn_pkg::ID_BITS_DEF,
  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
  localparam int SQ_W  = 2 * COUNT_BITS,
  localparam int EW    = $bits(hknn_pkg::hknn_ctl_t) + SQ_W + ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [hknn_pkg::FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]            in_bin_index,
  input  logic [COUNT_BITS-1:0]       in_bin_value,
  input  logic [ID_BITS-1:0]          in_candidate_id,
  input  logic                        in_last_bin,
  output logic                        q_push,
  output logic [EW-1:0]               q_data,
  input  logic                        q_full
);

  import hknn_pkg::*;

  logic                  accept;
  logic                  in_range;
  logic [COUNT_BITS-1:0] q_bin;
  logic                  s1_vld_r;
  hknn_ctl_t             s1_ctl_r;
  logic [COUNT_BITS-1:0] s1_val_r;
  logic [ID_BITS-1:0]    s1_id_r;
  logic                  need_push;
  logic                  s1_go;
  logic [COUNT_BITS-1:0] diff;
  logic [SQ_W-1:0]       sq;

  assign accept   = in_push & ~in_full;
  assign in_range = (32'(in_bin_index) < NUM_BINS);

  hknn_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_query_ram (
    .clk  (clk),
    .we   (accept && in_func == FUNC_LOAD && in_range),
    .waddr(in_bin_index),
    .wdata(in_bin_value),
    .re   (accept && in_func == FUNC_CAND && in_range),
    .raddr(in_bin_index),
    .rdata(q_bin)
  );

  assign need_push = (s1_ctl_r.func == FUNC_CAND) || (s1_ctl_r.func == FUNC_FLUSH);
  assign s1_go     = s1_vld_r & (~need_push | ~q_full);
  assign in_full   = s1_vld_r & ~s1_go;

  assign diff   = (q_bin >= s1_val_r) ? (q_bin - s1_val_r) : (s1_val_r - q_bin);
  assign sq     = diff * diff;
  assign q_push = s1_vld_r & need_push & ~q_full;
  assign q_data = {s1_ctl_r, sq, s1_id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r.func     <= in_func;
      s1_ctl_r.in_range <= in_range;
      s1_ctl_r.last     <= in_last_bin;
      s1_val_r          <= in_bin_value;
      s1_id_r           <= in_candidate_id;
    end
  end

endmodule

// ----- sv/hknn_back.sv -----
// Back part: accumulates distances, keeps the K-entry best list and ranks it on a flush.
// Depends on hknn_pkg; reads the command queue and writes the result queue.
module hknn_back #(
  parameter int TOP_K      = hknn_pkg::TOP_K_DEF,
  parameter int COUNT_BITS = hknn_pkg::COUNT_BITS_DEF,
  parameter int ID_BITS    = hknn_pkg::ID_BITS_DEF,
  localparam int SLOT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1,
  localparam int SQ_W   = 2 * COUNT_BITS,
  localparam int EW     = $bits(hknn_pkg::hknn_ctl_t) + SQ_W + ID_BITS,
  localparam int OW     = SLOT_W + ID_BITS + hknn_pkg::DIST_W + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [EW-1:0] q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          o_push,
  output logic [OW-1:0] o_data,
  input  logic          o_full
);

  import hknn_pkg::*;

  localparam int CNT_W = $clog2(TOP_K + 1);
  localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOP_K - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  hknn_ctl_t          h_ctl;
  logic [SQ_W-1:0]    h_sq;
  logic [ID_BITS-1:0] h_id;

  logic [1:0]         state_r;
  logic [DIST_W-1:0]  run_dist_r;
  logic [DIST_W-1:0]  cand_dist_r;
  logic [ID_BITS-1:0] cand_id_r;
  logic [DIST_W-1:0]  best_dist_r [TOP_K];
  logic [ID_BITS-1:0] best_id_r [TOP_K];
  logic [SLOT_W-1:0]  order_r [TOP_K];
  logic [CNT_W-1:0]   fill_cnt_r;
  logic [SLOT_W-1:0]  worst_slot_r;
  logic [DIST_W-1:0]  worst_dist_r;
  logic               scan_busy_r;
  logic [SLOT_W-1:0]  scan_idx_r;
  logic [SLOT_W-1:0]  scan_slot_r;
  logic [DIST_W-1:0]  scan_max_r;
  logic [SLOT_W-1:0]  idx_r;

  logic [SUM_W-1:0]   sum;
  logic [DIST_W-1:0]  add_dist;
  logic [SLOT_W-1:0]  rd_slot;
  logic [DIST_W-1:0]  rd_dist;
  logic [ID_BITS-1:0] rd_id;
  logic               list_full;
  logic               ins_go;
  logic               ins_we;
  logic [SLOT_W-1:0]  ins_slot;
  logic               scan_start;
  logic               scan_take;
  logic [DIST_W-1:0]  cur_max;
  logic [SLOT_W-1:0]  cur_slot;
  logic [TOP_K-1:0]   lt;
  logic               t_filled;
  logic [SLOT_W-1:0]  rank_t;
  logic               emit_valid;
  logic               emit_last;

  assign {h_ctl, h_sq, h_id} = q_data;

  assign sum      = SUM_W'(run_dist_r) + SUM_W'(h_sq);
  assign add_dist = !h_ctl.in_range ? run_dist_r :
                    (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

  assign q_pop = (state_r == ST_IDLE) & ~q_empty &
                 ((h_ctl.func != FUNC_FLUSH) | ~scan_busy_r);

  assign rd_slot = scan_busy_r ? scan_idx_r :
                   (state_r == ST_EMIT) ? order_r[idx_r] : idx_r;
  assign rd_dist = best_dist_r[rd_slot];
  assign rd_id   = best_id_r[rd_slot];

  assign list_full  = (fill_cnt_r == CNT_W'(TOP_K));
  assign ins_go     = (state_r == ST_INS) & ~scan_busy_r;
  assign ins_we     = ins_go & (~list_full | (cand_dist_r < worst_dist_r));
  assign ins_slot   = list_full ? worst_slot_r : fill_cnt_r[SLOT_W-1:0];
  assign scan_start = ins_we & (list_full | (fill_cnt_r == CNT_W'(TOP_K - 1)));

  assign scan_take = (scan_idx_r == '0) || (scan_max_r < rd_dist);
  assign cur_max   = scan_take ? rd_dist : scan_max_r;
  assign cur_slot  = scan_take ? scan_idx_r : scan_slot_r;

  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      lt[j] = (CNT_W'(j) < fill_cnt_r) &&
              ((best_dist_r[j] < rd_dist) ||
               ((best_dist_r[j] == rd_dist) && (SLOT_W'(j) < idx_r)));
    end
  end

  assign t_filled = (CNT_W'(idx_r) < fill_cnt_r);
  assign rank_t   = t_filled ? SLOT_W'($countones(lt)) : idx_r;

  assign emit_valid = (CNT_W'(idx_r) < fill_cnt_r);
  assign emit_last  = (idx_r == LAST_SLOT);
  assign o_push     = (state_r == ST_EMIT) & ~o_full;
  assign o_data     = {idx_r,
                       emit_valid ? rd_id : ID_BITS'(0),
                       emit_valid ? rd_dist : DIST_W'(0),
                       emit_valid,
                       emit_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_dist_r   <= '0;
      fill_cnt_r   <= '0;
      worst_slot_r <= '0;
      scan_busy_r  <= 1'b0;
      scan_idx_r   <= '0;
      idx_r        <= '0;
    end else begin
      if (scan_busy_r) begin
        if (scan_idx_r == LAST_SLOT) begin
          scan_busy_r  <= 1'b0;
          worst_slot_r <= cur_slot;
        end else begin
          scan_idx_r <= scan_idx_r + SLOT_W'(1);
        end
      end else if (scan_start) begin
        scan_busy_r <= 1'b1;
        scan_idx_r  <= '0;
      end

      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (h_ctl.func == FUNC_FLUSH) begin
              state_r <= ST_RANK;
              idx_r   <= '0;
            end else if (h_ctl.last) begin
              run_dist_r <= '0;
              state_r    <= ST_INS;
            end else begin
              run_dist_r <= add_dist;
            end
          end
        end
        ST_INS: begin
          if (ins_go) begin
            if (!list_full) begin
              fill_cnt_r <= fill_cnt_r + CNT_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        ST_RANK: begin
          if (idx_r == LAST_SLOT) begin
            idx_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        ST_EMIT: begin
          if (o_push) begin
            if (emit_last) begin
              fill_cnt_r   <= '0;
              worst_slot_r <= '0;
              idx_r        <= '0;
              state_r      <= ST_IDLE;
            end else begin
              idx_r <= idx_r + SLOT_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && h_ctl.func != FUNC_FLUSH && h_ctl.last) begin
      cand_dist_r <= add_dist;
      cand_id_r   <= h_id;
    end
    if (ins_we) begin
      best_dist_r[ins_slot] <= cand_dist_r;
      best_id_r[ins_slot]   <= cand_id_r;
    end
    if (scan_busy_r) begin
      scan_max_r  <= cur_max;
      scan_slot_r <= cur_slot;
      if (scan_idx_r == LAST_SLOT) begin
        worst_dist_r <= cur_max;
      end
    end
    if (state_r == ST_RANK) begin
      order_r[rank_t] <= idx_r;
    end
  end

endmodule

// ----- sv/histogram_top_k_nearest_search.sv -----
// Top level of the histogram top-K nearest search block.
// Depends on hknn_pkg, hknn_front, hknn_fifo and hknn_back.
//
// Usage: every input transfer carries one command. A query load stores one
// bin of the query histogram. A candidate bin adds the squared difference
// to the running distance; the bin marked last offers the candidate to
// the best list of TOP_K entries. A flush produces TOP_K result transfers in
// ascending distance order, filled slots first, then clears the list.
// Input side: push and full; result side: empty and pop.
// A transfer is registered in the front stage; candidate bins and flushes
// then wait in a four-entry command queue. The back takes one candidate
// bin per cycle while idle; a last bin adds an insert state, and each
// insertion that fills or changes a full list starts a worst-slot scan that
// runs alongside the following bins and holds back only the next last bin
// or flush. A flush first ranks all slots, then emits the results in order.
// When the receiver stalls, results wait in a two-entry result queue and
// the back, then the command queue and finally the input side fill up.
// Reset empties both queues and clears the list and the running distance;
// query bins keep undefined contents until they are loaded.
module histogram_top_k_nearest_search #(
  parameter int TOP_K      = hknn_pkg::TOP_K_DEF,
  parameter int NUM_BINS   = hknn_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hknn_pkg::COUNT_BITS_DEF,
  parameter int ID_BITS    = hknn_pkg::ID_BITS_DEF,
  localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
  localparam int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [hknn_pkg::FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]            in_bin_index,
  input  logic [COUNT_BITS-1:0]       in_bin_value,
  input  logic [ID_BITS-1:0]          in_candidate_id,
  input  logic                        in_last_bin,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [RANK_W-1:0]           out_rank,
  output logic [ID_BITS-1:0]          out_result_id,
  output logic [hknn_pkg::DIST_W-1:0] out_result_distance,
  output logic                        out_result_valid,
  output logic                        out_last_result
);

  import hknn_pkg::*;

  localparam int SQ_W = 2 * COUNT_BITS;
  localparam int EW   = $bits(hknn_ctl_t) + SQ_W + ID_BITS;
  localparam int OW   = RANK_W + ID_BITS + DIST_W + 2;

  logic          q_push;
  logic [EW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [EW-1:0] q_rdata;
  logic          q_empty;
  logic          o_push;
  logic [OW-1:0] o_wdata;
  logic          o_full;
  logic [OW-1:0] o_rdata;

  hknn_front #(
    .NUM_BINS  (NUM_BINS),
    .COUNT_BITS(COUNT_BITS),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_bin_index   (in_bin_index),
    .in_bin_value   (in_bin_value),
    .in_candidate_id(in_candidate_id),
    .in_last_bin    (in_last_bin),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  hknn_fifo #(
    .WIDTH(EW),
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  hknn_back #(
    .TOP_K     (TOP_K),
    .COUNT_BITS(COUNT_BITS),
    .ID_BITS   (ID_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_data (q_rdata),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .o_push (o_push),
    .o_data (o_wdata),
    .o_full (o_full)
  );

  hknn_fifo #(
    .WIDTH(OW),
    .DEPTH(RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (o_push),
    .wdata(o_wdata),
    .full (o_full),
    .pop  (out_pop),
    .rdata(o_rdata),
    .empty(out_empty)
  );

  assign {out_rank, out_result_id, out_result_distance, out_result_valid,
          out_last_result} = o_rdata;

  a_cmd_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Command queue written while full.");

  a_res_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full)
    else $error("Result queue written while full.");

  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_result) |-> (out_rank == RANK_W'(TOP_K - 1)))
    else $error("Final result of a flush carries a wrong rank.");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_result_valid) |-> (out_result_distance == '0 && out_result_id == '0))
    else $error("Unfilled slot reported with nonzero fields.");

endmodule
